[rtl/core/servo_frame_receiver_top_defines.svh]
// assertion macros shared by the servo frame receiver modules
`ifndef SERVO_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SERVO_FRAME_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SFR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("servo frame receiver check failed");

// next-cycle implication, checked on every rising edge out of reset
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("servo frame receiver check failed");

`endif

[rtl/core/sfr_pkg.sv]
// shared constants and types of the servo frame receiver
package sfr_pkg;

	localparam int unsigned SERVO_COUNT_DEF = 12;
	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned PULSE_W         = 16;
	localparam int unsigned CHAN_W          = 4;
	localparam int unsigned CFG_IDX_W       = 8;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 8'd1;

	// sync byte values after reset
	localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'd10;
	localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'd69;

	// a finished good frame, tagged with the payload bank holding it
	typedef struct packed {
		logic push;
		logic bank;
	} frame_cmd_t;

	// the back end has delivered every word of a bank
	typedef struct packed {
		logic done;
		logic bank;
	} frame_done_t;

endpackage

[rtl/core/sfr_byte_if.sv]
// received byte channel
interface sfr_byte_if;
	logic                      valid;
	logic                      ready;
	logic [sfr_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/core/sfr_result_if.sv]
// servo result channel
interface sfr_result_if;
	logic                       valid;
	logic                       ready;
	logic [sfr_pkg::CHAN_W-1:0]  servo_channel;
	logic [sfr_pkg::PULSE_W-1:0] pulse_width;
	logic                       last_of_frame;

	modport source (output valid, output servo_channel, output pulse_width,
		output last_of_frame, input ready);
	modport sink (input valid, input servo_channel, input pulse_width,
		input last_of_frame, output ready);
endinterface

[rtl/core/sfr_cfg_if.sv]
// configuration write channel
interface sfr_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [sfr_pkg::CFG_IDX_W-1:0] index;
	logic [sfr_pkg::BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/sfr_ram.sv]
// generic simple dual port ram with registered read
module sfr_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/sfr_front.sv]
// byte parser: sync hunt, payload capture, checksum test
`include "servo_frame_receiver_top_defines.svh"
module sfr_front #(
	parameter int unsigned SERVO_COUNT = sfr_pkg::SERVO_COUNT_DEF,
	parameter int unsigned PAIR_W      = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	sfr_byte_if.sink                   rx,
	sfr_cfg_if.sink                    cfg,
	output sfr_pkg::frame_cmd_t        cmd,
	input  logic                       q_full,
	input  sfr_pkg::frame_done_t       done,
	output logic                       ram_we,
	output logic [PAIR_W:0]            ram_waddr,
	output logic [sfr_pkg::PULSE_W-1:0] ram_wdata
);

	localparam int unsigned PAYLOAD_BYTES = 2 * SERVO_COUNT;
	localparam int unsigned CHECK_POS     = PAYLOAD_BYTES + 2;
	localparam int unsigned POS_W         = $clog2(CHECK_POS + 1);

	localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SYNC2 = POS_W'(1);
	localparam logic [POS_W-1:0] POS_DATA0 = POS_W'(2);
	localparam logic [POS_W-1:0] POS_CHECK = POS_W'(CHECK_POS);

	logic [POS_W-1:0]          pos_q;
	logic [sfr_pkg::BYTE_W-1:0] xor_q;
	logic [sfr_pkg::BYTE_W-1:0] lo_q;
	logic                      wbank_q;
	logic [1:0]                busy_q;
	logic [sfr_pkg::BYTE_W-1:0] first_q;
	logic [sfr_pkg::BYTE_W-1:0] second_q;

	logic             is_payload;
	logic             is_check;
	logic             acc;
	logic [POS_W-1:0] slot;
	logic [POS_W-1:0] half;

	// position decode
	assign is_payload = (pos_q >= POS_DATA0) && (pos_q < POS_CHECK);
	assign is_check   = (pos_q == POS_CHECK);
	assign slot       = pos_q - POS_DATA0;
	assign half       = slot >> 1;

	// stall on a payload byte while its bank is still draining, and on the checksum byte while the queue is full
	assign rx.ready = !(is_payload && busy_q[wbank_q]) && !(is_check && q_full);
	assign acc      = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	// byte pair written once the high byte arrives
	assign ram_we    = acc && is_payload && slot[0];
	assign ram_waddr = {wbank_q, half[PAIR_W-1:0]};
	assign ram_wdata = {rx.rx_byte, lo_q};

	// good checksum hands the bank to the back end
	assign cmd.push = acc && is_check && (xor_q == rx.rx_byte);
	assign cmd.bank = wbank_q;

	// frame position and running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			xor_q <= '0;
		end else if (acc) begin
			unique case (1'b1)
				(pos_q == POS_HUNT): begin
					pos_q <= (rx.rx_byte == first_q) ? POS_SYNC2 : POS_HUNT;
				end
				(pos_q == POS_SYNC2): begin
					pos_q <= (rx.rx_byte == second_q) ? POS_DATA0 : POS_HUNT;
					xor_q <= '0;
				end
				is_payload: begin
					pos_q <= pos_q + POS_W'(1);
					xor_q <= xor_q ^ rx.rx_byte;
				end
				default: begin
					pos_q <= POS_HUNT;
					xor_q <= '0;
				end
			endcase
		end
	end

	// low byte of the current pair
	always_ff @(posedge clk) begin
		if (acc && is_payload && !slot[0]) begin
			lo_q <= rx.rx_byte;
		end
	end

	// bank ownership: set on hand-off, cleared when fully delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbank_q <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			if (done.done) begin
				busy_q[done.bank] <= 1'b0;
			end
			if (cmd.push) begin
				busy_q[wbank_q] <= 1'b1;
				wbank_q         <= !wbank_q;
			end
		end
	end

	// sync byte registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= sfr_pkg::FIRST_SYNC_RST;
			second_q <= sfr_pkg::SECOND_SYNC_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				sfr_pkg::REG_FIRST_SYNC:  first_q  <= cfg.data;
				sfr_pkg::REG_SECOND_SYNC: second_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// a bank handed off is never one still in use
	`SFR_ASSERT_NOW(a_push_free_bank, cmd.push, !busy_q[wbank_q])

endmodule

[rtl/core/sfr_queue.sv]
// two-entry queue of finished frames between parser and output sequencer
`include "servo_frame_receiver_top_defines.svh"
module sfr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  sfr_pkg::frame_cmd_t cmd,
	output logic                full,
	output sfr_pkg::frame_cmd_t head,
	input  logic                pop
);

	logic       bank_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign head.push = (count_q != 2'd0);
	assign head.bank = bank_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			bank_q[wr_ptr_q] <= cmd.bank;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (cmd.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({cmd.push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`SFR_ASSERT_NOW(a_no_overflow, cmd.push, !full || pop)
	`SFR_ASSERT_NOW(a_no_underflow, pop, count_q != 2'd0)

endmodule

[rtl/core/sfr_back.sv]
// output sequencer: reads byte pairs of a bank and emits one word per servo
`include "servo_frame_receiver_top_defines.svh"
module sfr_back #(
	parameter int unsigned SERVO_COUNT = sfr_pkg::SERVO_COUNT_DEF,
	parameter int unsigned PAIR_W      = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sfr_pkg::frame_cmd_t        head,
	output logic                       pop,
	output sfr_pkg::frame_done_t       done,
	output logic                       ram_re,
	output logic [PAIR_W:0]            ram_raddr,
	input  logic [sfr_pkg::PULSE_W-1:0] ram_rdata,
	sfr_result_if.source               servo
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_SHOW = 2'd2;

	localparam logic [PAIR_W-1:0] LAST_K = PAIR_W'(SERVO_COUNT - 1);

	logic [1:0]        state_q;
	logic              bank_q;
	logic [PAIR_W-1:0] k_q;

	logic       last;
	logic       word_acc;
	logic [7:0] ch_wide;

	assign last     = (k_q == LAST_K);
	assign word_acc = servo.valid && servo.ready;
	assign ch_wide  = 8'(k_q) + 8'd1;

	assign pop       = (state_q == ST_IDLE) && head.push;
	assign ram_re    = (state_q == ST_READ);
	assign ram_raddr = {bank_q, k_q};

	assign done.done = word_acc && last;
	assign done.bank = bank_q;

	// result word straight from the registered ram read
	assign servo.valid         = (state_q == ST_SHOW);
	assign servo.servo_channel = ch_wide[sfr_pkg::CHAN_W-1:0];
	assign servo.pulse_width   = ram_rdata;
	assign servo.last_of_frame = last;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bank_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (head.push) begin
						bank_q  <= head.bank;
						k_q     <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (word_acc) begin
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + PAIR_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SFR_ASSERT_NEXT(a_pop_starts_frame, pop, (state_q == ST_READ) && (k_q == '0))
	`SFR_ASSERT_NEXT(a_done_goes_idle, done.done, state_q == ST_IDLE)

endmodule

[rtl/core/servo_frame_receiver_top.sv]
// top level of the servo frame receiver
// Bytes are taken one per cycle; input stalls only while both payload banks hold
// frames whose words are not all delivered.
// A good frame's checksum byte enters the frame queue, which the output sequencer pops;
// each word is then a ram read followed by a show that holds until the word is taken.
// Reset clears the frame position, checksum, banks and queue and restores the sync
// bytes to 10 and 69; the payload ram is not cleared and needs no clearing pass.
module servo_frame_receiver_top #(
	parameter int unsigned SERVO_COUNT = sfr_pkg::SERVO_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sfr_byte_if.sink     rx,
	sfr_result_if.source servo,
	sfr_cfg_if.sink      cfg
);

	localparam int unsigned PAIR_W    = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
	localparam int unsigned RAM_DEPTH = 2 * (2 ** PAIR_W);

	sfr_pkg::frame_cmd_t  cmd;
	sfr_pkg::frame_cmd_t  head;
	sfr_pkg::frame_done_t done;
	logic                 q_full;
	logic                 pop;

	logic                        ram_we;
	logic [PAIR_W:0]             ram_waddr;
	logic [sfr_pkg::PULSE_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [PAIR_W:0]             ram_raddr;
	logic [sfr_pkg::PULSE_W-1:0] ram_rdata;

	// parser
	sfr_front #(
		.SERVO_COUNT(SERVO_COUNT),
		.PAIR_W     (PAIR_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.cfg      (cfg),
		.cmd      (cmd),
		.q_full   (q_full),
		.done     (done),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata)
	);

	// two banks of byte pairs
	sfr_ram #(
		.WIDTH(sfr_pkg::PULSE_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// frame queue
	sfr_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.full  (q_full),
		.head  (head),
		.pop   (pop)
	);

	// output sequencer
	sfr_back #(
		.SERVO_COUNT(SERVO_COUNT),
		.PAIR_W     (PAIR_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.done     (done),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.servo    (servo)
	);

endmodule

[dv/servo_frame_checker.sv]
// scoreboard for the servo frame receiver: predicts servo words from received bytes and checks them
`timescale 1ns / 100ps

module servo_frame_checker #(
	parameter int unsigned SERVO_COUNT = sfr_pkg::SERVO_COUNT_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	sfr_byte_if   rx,
	sfr_result_if servo,
	sfr_cfg_if    cfg,
	output int    fail_count,
	output int    pending
);

	localparam int unsigned PAYLOAD_LEN = 2 * SERVO_COUNT;
	localparam int unsigned CHECK_POS   = PAYLOAD_LEN + 2;

	typedef struct packed {
		logic [sfr_pkg::CHAN_W-1:0]  chan;
		logic [sfr_pkg::PULSE_W-1:0] pulse;
		logic                        last;
	} servo_word_t;

	servo_word_t                 due_words[$];
	logic [sfr_pkg::BYTE_W-1:0]  first_sync;
	logic [sfr_pkg::BYTE_W-1:0]  second_sync;
	logic [sfr_pkg::BYTE_W-1:0]  frame_xor;
	logic [sfr_pkg::BYTE_W-1:0]  payload [PAYLOAD_LEN];
	int unsigned                 frame_pos;

	// advance the frame parser by one received byte, queue the words of a good frame
	task automatic take_rx_byte(input logic [sfr_pkg::BYTE_W-1:0] b);
		servo_word_t w;
		if (frame_pos == 0) begin
			frame_pos = (b == first_sync) ? 1 : 0;
		end else if (frame_pos == 1) begin
			// a wrong second sync byte drops back to hunting without being re-tested
			if (b == second_sync) begin
				frame_pos = 2;
				frame_xor = '0;
			end else begin
				frame_pos = 0;
			end
		end else if (frame_pos < CHECK_POS) begin
			payload[frame_pos - 2] = b;
			frame_xor ^= b;
			frame_pos++;
		end else begin
			// checksum byte: a mismatch drops the whole frame
			if (frame_xor == b) begin
				for (int k = 0; k < SERVO_COUNT; k++) begin
					w.chan  = sfr_pkg::CHAN_W'(k + 1);
					w.pulse = {payload[2 * k + 1], payload[2 * k]};
					w.last  = (k == SERVO_COUNT - 1);
					due_words.push_back(w);
				end
			end
			frame_pos = 0;
			frame_xor = '0;
		end
	endtask

	// compare one delivered servo word with the oldest one due
	task automatic check_servo_word();
		servo_word_t want;
		if (due_words.size() == 0) begin
			fail_count++;
			$display("%0t: servo word with none due: channel %0d width %h last %0b",
				$time, servo.servo_channel, servo.pulse_width, servo.last_of_frame);
		end else begin
			want = due_words.pop_front();
			if (servo.servo_channel !== want.chan) begin
				fail_count++;
				$display("%0t: servo_channel expected %0d got %0d",
					$time, want.chan, servo.servo_channel);
			end
			if (servo.pulse_width !== want.pulse) begin
				fail_count++;
				$display("%0t: pulse_width expected %h got %h",
					$time, want.pulse, servo.pulse_width);
			end
			if (servo.last_of_frame !== want.last) begin
				fail_count++;
				$display("%0t: last_of_frame expected %0b got %0b",
					$time, want.last, servo.last_of_frame);
			end
		end
	endtask

	// watch all three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync  = sfr_pkg::FIRST_SYNC_RST;
			second_sync = sfr_pkg::SECOND_SYNC_RST;
			frame_pos   = 0;
			frame_xor   = '0;
			fail_count  = 0;
			due_words.delete();
		end else begin
			if (servo.valid && servo.ready)
				check_servo_word();
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					sfr_pkg::REG_FIRST_SYNC: begin
						first_sync = cfg.data;
					end
					sfr_pkg::REG_SECOND_SYNC: begin
						second_sync = cfg.data;
					end
					default: begin
					end
				endcase
			end
			if (rx.valid && rx.ready)
				take_rx_byte(rx.rx_byte);
		end
		pending = due_words.size();
	end

endmodule

[dv/tb_top.sv]
// testbench top for the servo frame receiver: byte and config stimulus, result backpressure, verdict
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned SERVO_COUNT  = sfr_pkg::SERVO_COUNT_DEF;
	localparam int unsigned FRAME_LEN    = 2 * SERVO_COUNT + 3;
	localparam int          SETTLE_CYC   = 2 * SERVO_COUNT + 16;
	localparam int          HOLD_CYC     = 400;
	localparam int          CYCLE_LIMIT  = 200000;

	// indexes outside the register list, writes to them are dropped
	localparam logic [sfr_pkg::CFG_IDX_W-1:0] REG_PAST_LIST = 8'd2;
	localparam logic [sfr_pkg::CFG_IDX_W-1:0] REG_INDEX_MAX = 8'hFF;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_cnt;
	int   mixed_bytes;
	bit   hold_req;
	bit   burst_mode;
	logic [sfr_pkg::BYTE_W-1:0] first_sync_val;
	logic [sfr_pkg::BYTE_W-1:0] second_sync_val;

	sfr_byte_if   rx_if();
	sfr_result_if servo_if();
	sfr_cfg_if    cfg_if();

	servo_frame_receiver_top #(
		.SERVO_COUNT(SERVO_COUNT)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_if),
		.servo (servo_if),
		.cfg   (cfg_if)
	);

	servo_frame_checker #(
		.SERVO_COUNT(SERVO_COUNT)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.servo     (servo_if),
		.cfg       (cfg_if),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// idle length: mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 0;
		else if (r < 8)
			return $urandom_range(1, 3);
		else if (r < 9)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// result side backpressure, with one long hold-off on request
	initial begin
		@(negedge clk);
		forever begin
			if (hold_req) begin
				servo_if.ready <= 1'b0;
				repeat (HOLD_CYC) @(negedge clk);
				hold_req = 1'b0;
			end else if (burst_mode || $urandom_range(0, 2) != 0) begin
				servo_if.ready <= 1'b1;
				@(negedge clk);
			end else begin
				servo_if.ready <= 1'b0;
				repeat (pick_gap() + 1) @(negedge clk);
			end
		end
	end

	// offer one byte and wait until it is taken; valid stays high afterwards
	task automatic send_byte(input logic [sfr_pkg::BYTE_W-1:0] b);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// one register write on the config port
	task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
		input logic [sfr_pkg::BYTE_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// stop sending and let every due word drain, plus the back end latency
	task automatic settle();
		rx_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// new sync pair, written only with the block idle
	task automatic retune(input logic [sfr_pkg::BYTE_W-1:0] s1,
		input logic [sfr_pkg::BYTE_W-1:0] s2);
		settle();
		write_reg(sfr_pkg::REG_FIRST_SYNC, s1);
		write_reg(sfr_pkg::REG_SECOND_SYNC, s2);
		first_sync_val  = s1;
		second_sync_val = s2;
	endtask

	// sync pair, payload and checksum; extremes gives pulse widths of all zeros and all ones
	task automatic send_frame(input bit extremes, input bit bad_sum);
		logic [sfr_pkg::BYTE_W-1:0] b;
		logic [sfr_pkg::BYTE_W-1:0] sum;
		sum = '0;
		send_byte(first_sync_val);
		send_byte(second_sync_val);
		for (int i = 0; i < 2 * SERVO_COUNT; i++) begin
			if (extremes)
				b = ((i / 2) % 2) ? 8'hFF : 8'h00;
			else
				b = 8'($urandom);
			sum ^= b;
			send_byte(b);
		end
		if (bad_sum)
			sum ^= 8'(1 << $urandom_range(0, 7));
		send_byte(sum);
	endtask

	// mostly well formed frames, some bad checksums, broken sync pairs and noise
	task automatic run_mix(input int target);
		int r;
		int n;
		logic [sfr_pkg::BYTE_W-1:0] b;
		mixed_bytes = 0;
		while (mixed_bytes < target) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				send_frame(1'b0, $urandom_range(0, 6) == 0);
				mixed_bytes += FRAME_LEN;
			end else if (r < 9) begin
				// first sync followed by anything but the second
				b = second_sync_val ^ 8'($urandom_range(1, 255));
				send_byte(first_sync_val);
				send_byte(b);
				mixed_bytes += 2;
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom));
				mixed_bytes += n;
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n          = 1'b0;
		hold_req        = 1'b0;
		burst_mode      = 1'b0;
		cycle_cnt       = 0;
		rx_if.valid     = 1'b0;
		rx_if.rx_byte   = '0;
		cfg_if.valid    = 1'b0;
		cfg_if.index    = '0;
		cfg_if.data     = '0;
		servo_if.ready  = 1'b0;
		first_sync_val  = sfr_pkg::FIRST_SYNC_RST;
		second_sync_val = sfr_pkg::SECOND_SYNC_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// hunting noise and a wrong first sync byte
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(sfr_pkg::FIRST_SYNC_RST + 8'd1);
		// wrong second sync byte equal to the first is not taken as a new start
		send_byte(sfr_pkg::FIRST_SYNC_RST);
		send_byte(sfr_pkg::FIRST_SYNC_RST);
		send_byte(sfr_pkg::SECOND_SYNC_RST);

		// long hold-off on the result side while bytes keep coming back to back:
		// extreme pulse widths, a random frame, then a frame with a bad checksum
		// whose payload stalls until a bank is free
		settle();
		hold_req   = 1'b1;
		burst_mode = 1'b1;
		send_frame(1'b1, 1'b0);
		send_frame(1'b0, 1'b0);
		send_frame(1'b0, 1'b1);
		burst_mode = 1'b0;

		// extreme sync values and writes outside the register list
		retune(8'h00, 8'hFF);
		write_reg(REG_PAST_LIST, 8'hA5);
		write_reg(REG_INDEX_MAX, 8'h5A);
		run_mix(12);

		// identical sync bytes
		retune(8'h5C, 8'h5C);
		run_mix(12);

		settle();
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
